>>> hw/rtl/h264_fu_a_packetizer_core_assert.svh
// Assertion macros for the FU-A packetizer core.
// Used by the top level only; the bodies collapse to nothing in synthesis.
`ifndef H264_FU_A_PACKETIZER_CORE_ASSERT_SVH
`define H264_FU_A_PACKETIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define H264FU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("h264fu assertion failed");
`define H264FU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("h264fu implication failed");
`else
`define H264FU_ASSERT(lbl, prop)
`define H264FU_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/h264fu_pkg.sv
// Shared types and constants of the H.264 FU-A packetizer.
// No dependencies; imported by the result queue and the top level.
package h264fu_pkg;

    // FU-A header construction
    localparam logic [7:0] FU_A_TYPE = 8'd28;
    localparam logic [7:0] NRI_MASK  = 8'h60;
    localparam logic [7:0] TYPE_MASK = 8'h1f;
    localparam logic [7:0] START_BIT = 8'h80;
    localparam logic [7:0] END_BIT   = 8'h40;

    // Slice size limits and reset values
    localparam int unsigned SLICE_BITS  = 12;
    localparam int unsigned FILL_BITS   = 11;
    localparam logic [SLICE_BITS-1:0] SLICE_RESET = 12'd1024;
    localparam logic [SLICE_BITS-1:0] SLICE_MIN   = 12'd2;
    localparam logic [SLICE_BITS-1:0] SLICE_MAX   = 12'd2048;
    localparam logic [31:0] STEP_RESET = 32'(90000 / 25);

    // Default unit length width
    localparam int unsigned LENGTH_BITS_DEF = 20;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SLICE_SIZE = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TS_STEP    = 1'b1;

    // Result queue
    localparam int unsigned RES_MAX = 3;

    typedef struct packed {
        logic [31:0] ts_step;
        logic        marker;
        logic        pkt_end;
        logic [7:0]  byte_val;
    } result_t;

    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } fill_req_t;

endpackage

>>> hw/rtl/h264fu_out_queue.sv
// Three-slot result queue: loaded with all bytes of one item, drained one per cycle while pop_ready is high.
// Depends on h264fu_pkg.
module h264fu_out_queue
    import h264fu_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fill_req_t                 fill,
    input  result_t [RES_MAX-1:0]     load_items,
    input  logic                      pop_ready,
    output logic                      head_valid,
    output result_t                   head,
    output logic                      load_ready
);

    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    result_t [RES_MAX-1:0]  slot_reg;
    result_t [RES_MAX-1:0]  slot_next;
    logic                   pop;

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot_reg[0];
    assign pop        = head_valid && pop_ready;
    // Accept a new load once the queue empties this cycle
    assign load_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop_ready);

    // Load a new set or shift one slot down on a pop
    always_comb begin
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        if (fill.load) begin
            cnt_next  = fill.count;
            slot_next = load_items;
        end else if (pop) begin
            cnt_next     = cnt_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

endmodule

>>> hw/rtl/h264_fu_a_packetizer_core.sv
// H.264 FU-A packetizer top level: unit state, fragment logic, config registers.
// Depends on h264fu_pkg, h264fu_out_queue and h264_fu_a_packetizer_core_assert.svh.
//
// Usage:
//   s_ channel carries NAL unit bytes, header byte first, with s_tuser high on the
//   header byte and the unit length in s_tdata alongside it. m_ channel carries
//   packet bytes with the FU-A indicator and FU header inserted; m_tlast marks the
//   last byte of a packet, m_tuser the marker bit, and the timestamp step rides in
//   the upper bits of m_tdata.
//   Each accepted item yields zero to three output items. They are computed in the
//   cycle of acceptance, registered in the result queue and appear on m_ in the next cycle.
//   An item yielding one output sustains one item per cycle while m_tready is high; an
//   item yielding two or three outputs holds s_tready low while the three-slot result
//   queue drains at one byte per cycle whenever m_tready is high.
//   When m_tready is low the queue holds its head; s_tready stays low while the
//   queue holds any byte that cannot leave in the same cycle. The config port writes
//   slice size (index 0) and timestamp step (index 1); write only while idle.
//   Reset (aresetn low, synchronous) empties the queue, closes any open unit and
//   loads slice size 1024 and timestamp step 3600.
`include "h264_fu_a_packetizer_core_assert.svh"
module h264_fu_a_packetizer_core
    import h264fu_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int unsigned S_DATA_W    = ((8 + LENGTH_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input items
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_DATA_W-1:0]      s_tdata,   // data_byte, unit_length, zero pad
    input  logic                     s_tuser,   // unit_start
    // Result items
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [39:0]              m_tdata,   // out_byte, timestamp_step
    output logic                     m_tlast,
    output logic                     m_tuser,   // marker
    // Configuration writes
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [31:0]              cfg_wdata
);

    logic [SLICE_BITS-1:0]  slice_size_reg;
    logic [31:0]            ts_step_reg;
    logic [LENGTH_BITS-1:0] bytes_left_reg;
    logic [LENGTH_BITS-1:0] bytes_left_next;
    logic [FILL_BITS-1:0]   slice_fill_reg;
    logic [FILL_BITS-1:0]   slice_fill_next;
    logic                   fragmenting_reg;
    logic                   fragmenting_next;
    logic                   first_frag_reg;
    logic                   first_frag_next;
    logic [7:0]             unit_header_reg;
    logic [7:0]             unit_header_next;

    logic                   s_fire;
    logic [7:0]             in_byte;
    logic [LENGTH_BITS-1:0] in_len;
    logic [SLICE_BITS-1:0]  slice_eff;
    fill_req_t              fill;
    result_t [RES_MAX-1:0]  items;
    result_t                head;
    logic                   q_ready;

    assign in_byte = s_tdata[7:0];
    assign in_len  = s_tdata[8 +: LENGTH_BITS];
    assign s_tready = q_ready;
    assign s_fire   = s_tvalid && q_ready;

    // Clamp slice size into its legal range
    always_comb begin
        if (slice_size_reg < SLICE_MIN) begin
            slice_eff = SLICE_MIN;
        end else if (slice_size_reg > SLICE_MAX) begin
            slice_eff = SLICE_MAX;
        end else begin
            slice_eff = slice_size_reg;
        end
    end

    // Work out the output bytes and next unit state for the offered item
    always_comb begin
        logic [LENGTH_BITS-1:0] len;
        logic [LENGTH_BITS-1:0] bl_dec;
        logic [SLICE_BITS-1:0]  cap;
        logic [LENGTH_BITS:0]   fill_sum;
        logic [SLICE_BITS-1:0]  fill_inc;
        logic                   last;
        logic                   pend;
        logic [31:0]            ts;
        logic [7:0]             hdr_ind;
        logic [7:0]             hdr_fu;
        result_t                pay;

        len      = (in_len == '0) ? LENGTH_BITS'(1) : in_len;
        bl_dec   = bytes_left_reg - LENGTH_BITS'(1);
        cap      = first_frag_reg ? (slice_eff - SLICE_BITS'(1)) : slice_eff;
        fill_sum = {1'b0, bytes_left_reg} + (LENGTH_BITS + 1)'(slice_fill_reg);
        fill_inc = {1'b0, slice_fill_reg} + SLICE_BITS'(1);
        last     = !first_frag_reg && (fill_sum <= (LENGTH_BITS + 1)'(cap));
        pend     = (fill_inc >= cap) || (bl_dec == '0);
        ts       = first_frag_reg ? ts_step_reg : 32'd0;
        hdr_ind  = '0;
        hdr_fu   = '0;
        pay      = '0;

        bytes_left_next  = bytes_left_reg;
        slice_fill_next  = slice_fill_reg;
        fragmenting_next = fragmenting_reg;
        first_frag_next  = first_frag_reg;
        unit_header_next = unit_header_reg;
        items            = '0;
        fill.load        = s_fire;
        fill.count       = 2'd0;

        if (s_tuser) begin
            // Open a new unit; any open unit is dropped
            unit_header_next = in_byte;
            slice_fill_next  = '0;
            bytes_left_next  = len - LENGTH_BITS'(1);
            hdr_ind = (in_byte & NRI_MASK) | FU_A_TYPE;
            hdr_fu  = (in_byte & TYPE_MASK) | START_BIT;
            if (len <= LENGTH_BITS'(slice_eff)) begin
                fragmenting_next = 1'b0;
                first_frag_next  = 1'b0;
                items[0] = '{ts_step: ts_step_reg, marker: 1'b1,
                             pkt_end: (len == LENGTH_BITS'(1)), byte_val: in_byte};
                fill.count = 2'd1;
            end else begin
                fragmenting_next = 1'b1;
                first_frag_next  = 1'b1;
                items[0] = '{ts_step: ts_step_reg, marker: 1'b0,
                             pkt_end: 1'b0, byte_val: hdr_ind};
                items[1] = '{ts_step: ts_step_reg, marker: 1'b0,
                             pkt_end: 1'b0, byte_val: hdr_fu};
                fill.count = 2'd2;
            end
        end else if (bytes_left_reg == '0) begin
            // Drop bytes outside a unit
            fill.count = 2'd0;
        end else if (!fragmenting_reg) begin
            // Pass a single-packet unit through
            bytes_left_next = bl_dec;
            items[0] = '{ts_step: ts_step_reg, marker: 1'b1,
                         pkt_end: (bl_dec == '0), byte_val: in_byte};
            fill.count = 2'd1;
        end else begin
            // Fragment payload byte, headers in front at each later fragment start
            bytes_left_next = bl_dec;
            pay = '{ts_step: ts, marker: (last || (bl_dec == '0)),
                    pkt_end: pend, byte_val: in_byte};
            hdr_ind = (unit_header_reg & NRI_MASK) | FU_A_TYPE;
            hdr_fu  = (unit_header_reg & TYPE_MASK) | (last ? END_BIT : 8'd0);
            if ((slice_fill_reg == '0) && !first_frag_reg) begin
                items[0] = '{ts_step: ts, marker: last, pkt_end: 1'b0, byte_val: hdr_ind};
                items[1] = '{ts_step: ts, marker: last, pkt_end: 1'b0, byte_val: hdr_fu};
                items[2] = pay;
                fill.count = 2'd3;
            end else begin
                items[0] = pay;
                fill.count = 2'd1;
            end
            if (pend) begin
                slice_fill_next = '0;
                first_frag_next = 1'b0;
                if (bl_dec == '0) begin
                    fragmenting_next = 1'b0;
                end
            end else begin
                slice_fill_next = fill_inc[FILL_BITS-1:0];
            end
        end
    end

    // Advance unit state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg  <= '0;
            slice_fill_reg  <= '0;
            fragmenting_reg <= 1'b0;
            first_frag_reg  <= 1'b0;
            unit_header_reg <= '0;
        end else if (s_fire) begin
            bytes_left_reg  <= bytes_left_next;
            slice_fill_reg  <= slice_fill_next;
            fragmenting_reg <= fragmenting_next;
            first_frag_reg  <= first_frag_next;
            unit_header_reg <= unit_header_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_size_reg <= SLICE_RESET;
            ts_step_reg    <= STEP_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SLICE_SIZE: slice_size_reg <= cfg_wdata[SLICE_BITS-1:0];
                CFG_TS_STEP:    ts_step_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    h264fu_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fill       (fill),
        .load_items (items),
        .pop_ready  (m_tready),
        .head_valid (m_tvalid),
        .head       (head),
        .load_ready (q_ready)
    );

    assign m_tdata = {head.ts_step, head.byte_val};
    assign m_tlast = head.pkt_end;
    assign m_tuser = head.marker;

    // Unit state consistency
    `H264FU_ASSERT_IMPL(a_frag_has_bytes, fragmenting_reg, bytes_left_reg != '0)
    `H264FU_ASSERT_IMPL(a_fill_only_frag, slice_fill_reg != '0, fragmenting_reg)
    `H264FU_ASSERT_IMPL(a_first_only_frag, first_frag_reg, fragmenting_reg)
    `H264FU_ASSERT(a_no_load_when_full, !(s_fire && (fill.count == 2'd0) && m_tvalid && !m_tready))

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the H.264 FU-A packetizer core: drives NAL unit bytes with
// random handshake gaps and checks every packet byte against a built-in fragmenting model.
// Depends on h264fu_pkg and h264_fu_a_packetizer_core.
module tb_top;
    import h264fu_pkg::*;

    // Fragmenting model plus store of packet bytes still due from the block
    class fu_a_packet_checker;
        logic [SLICE_BITS-1:0] slice_reg;
        logic [31:0]           step_reg;
        int unsigned           bytes_left;
        int unsigned           fill;
        bit                    fragmenting;
        bit                    first_frag;
        logic [7:0]            unit_hdr;
        result_t               packet_bytes_due[$];
        int unsigned           fail_count;

        function new();
            slice_reg   = SLICE_RESET;
            step_reg    = STEP_RESET;
            bytes_left  = 0;
            fill        = 0;
            fragmenting = 0;
            first_frag  = 0;
            unit_hdr    = '0;
            fail_count  = 0;
        endfunction

        function void write_register(logic [CFG_ADDR_BITS-1:0] idx, logic [31:0] value);
            if (idx == CFG_SLICE_SIZE) begin
                slice_reg = value[SLICE_BITS-1:0];
            end else if (idx == CFG_TS_STEP) begin
                step_reg = value;
            end
        endfunction

        // Clamp the slice register into its legal range
        function int unsigned slice_eff();
            if (slice_reg < SLICE_MIN) return SLICE_MIN;
            if (slice_reg > SLICE_MAX) return SLICE_MAX;
            return slice_reg;
        endfunction

        function int unsigned pending();
            return packet_bytes_due.size();
        endfunction

        function void due(logic [7:0] b, bit pkt_end, bit marker, logic [31:0] ts);
            result_t r;
            r.byte_val = b;
            r.pkt_end  = pkt_end;
            r.marker   = marker;
            r.ts_step  = ts;
            packet_bytes_due.push_back(r);
        endfunction

        // Work out the packet bytes caused by one accepted unit byte
        function void fragment_byte(logic [7:0] b, bit start, logic [19:0] len_in);
            int unsigned slice;
            int unsigned cap;
            int unsigned len;
            logic [31:0] ts;
            bit          last_pkt;
            bit          frag_end;
            slice = slice_eff();
            if (start) begin
                len        = (len_in == 0) ? 1 : len_in;
                unit_hdr   = b;
                fill       = 0;
                bytes_left = len - 1;
                if (len <= slice) begin
                    fragmenting = 0;
                    first_frag  = 0;
                    due(b, bytes_left == 0, 1'b1, step_reg);
                end else begin
                    fragmenting = 1;
                    first_frag  = 1;
                    due((unit_hdr & NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0, step_reg);
                    due((unit_hdr & TYPE_MASK) | START_BIT, 1'b0, 1'b0, step_reg);
                end
                return;
            end
            // Drop bytes that arrive with no unit open
            if (bytes_left == 0) return;
            if (!fragmenting) begin
                bytes_left--;
                due(b, bytes_left == 0, 1'b1, step_reg);
                return;
            end
            cap      = first_frag ? slice - 1 : slice;
            ts       = first_frag ? step_reg : 32'd0;
            last_pkt = !first_frag && (bytes_left + fill <= cap);
            // Insert indicator and FU header in front of a later fragment's first byte
            if (fill == 0 && !first_frag) begin
                due((unit_hdr & NRI_MASK) | FU_A_TYPE, 1'b0, last_pkt, ts);
                due((unit_hdr & TYPE_MASK) | (last_pkt ? END_BIT : 8'h00), 1'b0, last_pkt, ts);
            end
            fill++;
            bytes_left--;
            frag_end = (fill >= cap) || (bytes_left == 0);
            due(b, frag_end, last_pkt || (bytes_left == 0), ts);
            if (frag_end) begin
                fill       = 0;
                first_frag = 0;
                if (bytes_left == 0) fragmenting = 0;
            end
        endfunction

        // Compare one accepted packet byte with the oldest one due
        function void check_packet_byte(result_t got);
            result_t want;
            if (packet_bytes_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected packet byte %02h last=%0b marker=%0b step=%08h",
                             got.byte_val, got.pkt_end, got.marker, got.ts_step);
                return;
            end
            want = packet_bytes_due.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("packet byte mismatch: want %02h/%0b/%0b/%08h got %02h/%0b/%0b/%08h",
                             want.byte_val, want.pkt_end, want.marker, want.ts_step,
                             got.byte_val, got.pkt_end, got.marker, got.ts_step);
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [31:0]              s_tdata;   // data_byte, unit_length, zero pad
    logic                     s_tuser;   // unit_start
    logic                     m_tvalid;
    logic                     m_tready;
    logic [39:0]              m_tdata;   // out_byte, timestamp_step
    logic                     m_tlast;
    logic                     m_tuser;   // marker
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [31:0]              cfg_wdata;

    fu_a_packet_checker packet_check = new();

    int unsigned tx_gap_max;
    int unsigned rx_gap_max;
    int unsigned rx_hold_cycles;
    int unsigned unit_bytes_sent;

    h264_fu_a_packetizer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Record accepted unit bytes and check accepted packet bytes
    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                packet_check.fragment_byte(s_tdata[7:0], s_tuser, s_tdata[27:8]);
            if (m_tvalid && m_tready) begin
                got.byte_val = m_tdata[7:0];
                got.ts_step  = m_tdata[39:8];
                got.pkt_end  = m_tlast;
                got.marker   = m_tuser;
                packet_check.check_packet_byte(got);
            end
        end
    end

    // Receiver: random stall per packet byte, plus an occasional long hold-off
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold_cycles != 0) begin
                m_tready = 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold_cycles = 0;
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap != 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Offer one unit byte after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic start, input logic [19:0] len);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) repeat (gap) @(negedge aclk);
        s_tdata  = {4'h0, len, b};
        s_tuser  = start;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Header byte with length, then random payload; fewer bytes than len abandons the unit
    task automatic send_unit(input logic [7:0] hdr, input logic [19:0] len,
                             input int unsigned nbytes);
        send_byte(hdr, 1'b1, len);
        unit_bytes_sent++;
        repeat (nbytes - 1) begin
            send_byte(8'($urandom), 1'b0, 20'($urandom));
            unit_bytes_sent++;
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] value);
        cfg_addr  = idx;
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
        packet_check.write_register(idx, value);
    endtask

    // Hold the sender until every due packet byte is out, then let the pipe settle
    task automatic wait_drained();
        while (packet_check.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic send_random_unit();
        int unsigned slice_now;
        int unsigned len_max;
        int unsigned len;
        int unsigned nbytes;
        int unsigned roll;
        slice_now = packet_check.slice_eff();
        len_max   = (3 * slice_now + 2 < 40) ? 3 * slice_now + 2 : 40;
        roll      = $urandom_range(0, 99);
        if (roll < 6) begin
            len    = 0;
            nbytes = 1;
        end else if (roll < 12) begin
            // huge length, cut short by the next unit
            len    = $urandom_range(1, 20'hFFFFF);
            nbytes = $urandom_range(1, 4);
            if (nbytes > len) nbytes = len;
        end else begin
            len    = $urandom_range(1, len_max);
            nbytes = (roll < 20) ? $urandom_range(1, len) : len;
        end
        send_unit(8'($urandom), 20'(len), nbytes);
        // stray bytes between units
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 20'($urandom));
    endtask

    initial begin
        int unsigned phase;
        int unsigned pick;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = CFG_SLICE_SIZE;
        cfg_wdata       = '0;
        aresetn         = 1'b0;
        tx_gap_max      = 19;
        rx_gap_max      = 19;
        rx_hold_cycles  = 0;
        unit_bytes_sent = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: stray byte with no unit open, then a zero-length unit at reset values
        send_byte(8'hFF, 1'b0, 20'hFFFFF);
        send_unit(8'h00, 20'd0, 1);
        wait_drained();
        // Slice below minimum, largest step
        write_reg(CFG_SLICE_SIZE, 32'd1);
        write_reg(CFG_TS_STEP, 32'hFFFF_FFFF);
        send_unit(8'hE5, 20'd2, 2);
        // Fragmented unit: at most two payload bytes per fragment, with inserted headers
        send_unit(8'hFF, 20'd5, 5);
        // Longest length, abandoned by a new unit
        send_unit(8'h7C, 20'hFFFFF, 3);
        send_unit(8'h41, 20'd3, 3);
        wait_drained();
        // Slice above maximum, zero step
        write_reg(CFG_SLICE_SIZE, 32'd4095);
        write_reg(CFG_TS_STEP, 32'd0);
        send_unit(8'h65, 20'd3, 3);
        wait_drained();
        // Shrink the slice below the fill of an open fragment
        write_reg(CFG_SLICE_SIZE, 32'd8);
        write_reg(CFG_TS_STEP, $urandom);
        send_unit(8'h7C, 20'd10, 5);
        wait_drained();
        write_reg(CFG_SLICE_SIZE, 32'd0);
        repeat (5) begin
            send_byte(8'($urandom), 1'b0, 20'($urandom));
            unit_bytes_sent++;
        end

        // Random phases, each with its own settings and idling
        phase = 0;
        while (unit_bytes_sent < 260) begin
            wait_drained();
            pick = $urandom_range(0, 9);
            case (pick)
                0:       write_reg(CFG_SLICE_SIZE, 32'd0);
                1:       write_reg(CFG_SLICE_SIZE, 32'd1);
                2:       write_reg(CFG_SLICE_SIZE, 32'd2);
                3:       write_reg(CFG_SLICE_SIZE, 32'd2048);
                4:       write_reg(CFG_SLICE_SIZE, 32'd4095);
                default: write_reg(CFG_SLICE_SIZE, $urandom_range(2, 12));
            endcase
            pick = $urandom_range(0, 3);
            case (pick)
                0:       write_reg(CFG_TS_STEP, 32'd0);
                1:       write_reg(CFG_TS_STEP, 32'hFFFF_FFFF);
                2:       write_reg(CFG_TS_STEP, 32'd3600);
                default: write_reg(CFG_TS_STEP, $urandom);
            endcase
            tx_gap_max = $urandom_range(0, 1) ? 19 : 0;
            rx_gap_max = $urandom_range(0, 1) ? 19 : 0;
            if (phase == 1) begin
                // back up the result queue so the input stalls
                write_reg(CFG_SLICE_SIZE, 32'd3);
                tx_gap_max     = 0;
                rx_gap_max     = 0;
                rx_hold_cycles = 60;
            end
            repeat (5) begin
                send_random_unit();
                if ($urandom_range(0, 7) == 0) wait_drained();
            end
            phase++;
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (packet_check.fail_count == 0 && packet_check.pending() == 0) begin
            $display("[h264_fu_a_packetizer_core] OK");
        end else begin
            $display("[h264_fu_a_packetizer_core] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("[h264_fu_a_packetizer_core] ERROR");
        $finish;
    end
endmodule
